### src/ordered_list_engine_macros.svh
// ----------------------------------------------------------------------------
// ordered list engine assertion macros
// concurrent checks on clk with asynchronous reset arst_n, off in synthesis
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every edge outside reset
`define OLE_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("ordered list engine check failed");

// consequent holds in the same cycle as the antecedent
`define OLE_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ordered list engine check failed");

// consequent holds in the cycle after the antecedent
`define OLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ordered list engine check failed");

`else

`define OLE_ASSERT_ALWAYS(label, expr)
`define OLE_ASSERT_IMPLIES(label, ante, cons)
`define OLE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### src/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// sizes, request and status codes and ring addressing for the list engine
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SUM_W    = IDX_W + 1;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 8;
	localparam int CMP_W    = POS_W + 1;
	localparam int OUT_W    = 7;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEL_LAST = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DEL_HEAD = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SEARCH   = 2'd3;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	// logical slot to physical ram address, ring starting at head
	function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
			input logic [IDX_W-1:0] lidx);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, head} + {1'b0, lidx};
		if (sum >= SUM_W'(CAPACITY)) begin
			sum = sum - SUM_W'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

### src/ole_ram.sv
// ----------------------------------------------------------------------------
// ole_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### src/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// delete last, delete first, bad position, full, empty and append: result in the cycle after start
// insert inside the list: one ram move per cycle from the tail
// search: one ram read per cycle from the front, stopping at the first match or the last entry
// busy until the result beat; done pulses one cycle, receiver cannot stall; reset empties list
// ----------------------------------------------------------------------------
module ordered_list_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ole_pkg::KIND_W-1:0]    kind,
	input  logic signed [ole_pkg::DATA_W-1:0] item_value,
	input  logic [ole_pkg::POS_W-1:0]     position,
	output logic                          done,
	output logic [ole_pkg::STATUS_W-1:0]  status,
	output logic [ole_pkg::OUT_W-1:0]     found_at,
	output logic [ole_pkg::OUT_W-1:0]     entry_count
);

	import ole_pkg::*;

	`include "ordered_list_engine_macros.svh"

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SHIFT  = 4'b0010,
		S_PUT    = 4'b0100,
		S_SEARCH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// list lives in a ring: head_q is the physical slot of position 1,
	// so dropping the first entry is just a head bump, no data moves
	logic [IDX_W-1:0]    head_q, head_d;
	logic [CNT_W-1:0]    count_q, count_d;

	// idx_s1 is the logical slot whose read data shows up on rd_data this cycle
	logic [IDX_W-1:0]    idx_s1, idx_d;
	logic [IDX_W-1:0]    stop_q, stop_d;   // logical slot that receives the new value
	logic [DATA_W-1:0]   key_q, key_d;     // insert value or search key

	// result beat
	logic                done_q, done_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [OUT_W-1:0]    found_q, found_d;

	// ram port
	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic [DATA_W-1:0]   wdata;
	logic [IDX_W-1:0]    raddr;
	logic [DATA_W-1:0]   rd_data;
	logic [IDX_W-1:0]    rd_lidx;

	// request decode helpers
	logic [CNT_W-1:0]    cnt_m1;
	logic [POS_W-1:0]    pos_m1;
	logic [CMP_W-1:0]    pos_w;
	logic [CMP_W-1:0]    cnt_p1_w;

	assign cnt_m1   = count_q - CNT_W'(1);
	assign pos_m1   = position - POS_W'(1);
	assign pos_w    = {1'b0, position};
	assign cnt_p1_w = CMP_W'(count_q) + CMP_W'(1);

	ole_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// reads and writes go through the ring mapping
	assign raddr = phys_addr(head_q, rd_lidx);

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		count_d  = count_q;
		idx_d    = idx_s1;
		stop_d   = stop_q;
		key_d    = key_q;
		done_d   = 1'b0;
		status_d = ST_OK;
		found_d  = '0;
		we       = 1'b0;
		waddr    = phys_addr(head_q, idx_s1 + IDX_W'(1));
		wdata    = rd_data;
		rd_lidx  = idx_s1;

		case (state_q)
			S_IDLE: begin
				// an insert that shifts starts at the tail, a search at the front
				if (kind == KIND_INSERT) begin
					rd_lidx = cnt_m1[IDX_W-1:0];
				end else begin
					rd_lidx = '0;
				end
				if (start) begin
					key_d = item_value;
					case (kind)
						KIND_INSERT: begin
							done_d = 1'b1;
							if (position == '0) begin
								status_d = ST_BADPOS;
							end else if (count_q == CNT_W'(CAPACITY)) begin
								status_d = ST_FULL;
							end else if (pos_w > cnt_p1_w) begin
								status_d = ST_BADPOS;
							end else if (pos_w == cnt_p1_w) begin
								// append at the tail, nothing to move
								we      = 1'b1;
								waddr   = phys_addr(head_q, count_q[IDX_W-1:0]);
								wdata   = item_value;
								count_d = count_q + CNT_W'(1);
							end else begin
								// tail read is in flight, walk down to the insert slot
								done_d  = 1'b0;
								idx_d   = cnt_m1[IDX_W-1:0];
								stop_d  = pos_m1[IDX_W-1:0];
								state_d = S_SHIFT;
							end
						end
						KIND_DEL_LAST: begin
							done_d = 1'b1;
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								count_d = cnt_m1;
							end
						end
						KIND_DEL_HEAD: begin
							done_d = 1'b1;
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								count_d = cnt_m1;
								head_d  = phys_addr(head_q, IDX_W'(1));
							end
						end
						KIND_SEARCH: begin
							if (count_q == '0) begin
								done_d   = 1'b1;
								status_d = ST_EMPTY;
							end else begin
								idx_d   = '0;
								state_d = S_SEARCH;
							end
						end
						default: begin
							done_d   = 1'b1;
							status_d = ST_BADPOS;
						end
					endcase
				end
			end

			S_SHIFT: begin
				// move slot idx up by one; the next read (idx - 1) never hits
				// the slot being written (idx + 1), so no forwarding is needed
				we      = 1'b1;
				rd_lidx = idx_s1 - IDX_W'(1);
				if (idx_s1 == stop_q) begin
					state_d = S_PUT;
				end else begin
					idx_d = idx_s1 - IDX_W'(1);
				end
			end

			S_PUT: begin
				// drop the new value into the freed slot
				we       = 1'b1;
				waddr    = phys_addr(head_q, stop_q);
				wdata    = key_q;
				count_d  = count_q + CNT_W'(1);
				done_d   = 1'b1;
				state_d  = S_IDLE;
			end

			S_SEARCH: begin
				rd_lidx = idx_s1 + IDX_W'(1);
				if (rd_data == key_q) begin
					done_d   = 1'b1;
					found_d  = OUT_W'(idx_s1) + OUT_W'(1);
					state_d  = S_IDLE;
				end else if (idx_s1 == cnt_m1[IDX_W-1:0]) begin
					done_d   = 1'b1;
					status_d = ST_NOTFOUND;
					state_d  = S_IDLE;
				end else begin
					idx_d = idx_s1 + IDX_W'(1);
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		idx_s1   <= idx_d;
		stop_q   <= stop_d;
		key_q    <= key_d;
		status_q <= status_d;
		found_q  <= found_d;
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found_at    = found_q;
	assign entry_count = OUT_W'(count_q);

	// checks
	`OLE_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY))
	`OLE_ASSERT_IMPLIES(a_done_idle, done, !busy)
	`OLE_ASSERT_IMPLIES(a_shift_no_overlap, (state_q == S_SHIFT && idx_s1 != stop_q), waddr != raddr)
	`OLE_ASSERT_NEXT(a_match_reports, (state_q == S_SEARCH && rd_data == key_q), (done && status == ST_OK && found_at != '0))
	`OLE_ASSERT_IMPLIES(a_count_moves_on_done, !done, $stable(count_q))

endmodule
